/* hdl/fasta_pattern_locator_assert.svh */
// ----------------------------------------------------------------------------
// fasta_pattern_locator assertion macros
// Shorthand for clocked implication checks with async active-low reset.
// ----------------------------------------------------------------------------
`ifndef FASTA_PATTERN_LOCATOR_ASSERT_SVH
`define FASTA_PATTERN_LOCATOR_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define FPL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define FPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/fpl_pkg.sv */
// ----------------------------------------------------------------------------
// fpl_pkg
// Shared constants and types for the FASTA pattern locator.
// ----------------------------------------------------------------------------
package fpl_pkg;

    localparam int POS_W      = 48;
    localparam int REC_W      = 32;
    localparam int PAT_W      = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int BYTE_W     = 8;

    localparam int MAX_PATTERN_DEF = 8;

    localparam logic [BYTE_W-1:0] HEADER_MARK  = 8'h3E;  // '>'
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;  // '\n'

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 4'd1;

    // Per-byte scan outcome handed from the scanner to the top level
    typedef struct packed {
        logic             seq;        // byte is sequence data
        logic             full;       // enough record bytes for a compare
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
        logic [REC_W-1:0] rec;
    } scan_res_t;

endpackage

/* hdl/fpl_match.sv */
// ----------------------------------------------------------------------------
// fpl_match
// Parallel compare of the newest window bytes against the pattern.
// ----------------------------------------------------------------------------
module fpl_match
    import fpl_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic [MAX_PATTERN*BYTE_W-1:0] window,   // newest byte in [7:0]
    input  logic [PAT_W-1:0]              pattern,
    input  logic [LEN_W-1:0]              len,      // already clamped to 1..MAX
    output logic                          hit
);

    logic [MAX_PATTERN-1:0] hit_by_len;

    // For length l, window byte i must equal pattern byte l-1-i
    always_comb
    begin
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            hit_by_len[l-1] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (window[i*BYTE_W +: BYTE_W] != pattern[(l-1-i)*BYTE_W +: BYTE_W])
                begin
                    hit_by_len[l-1] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int l = 1; l <= MAX_PATTERN; l++)
        begin
            if (len == LEN_W'(l))
            begin
                hit = hit_by_len[l-1];
            end
        end
    end

endmodule

/* hdl/fpl_scan.sv */
// ----------------------------------------------------------------------------
// fpl_scan
// Record state: header mode, in-record position, record count, byte window.
// ----------------------------------------------------------------------------
module fpl_scan
    import fpl_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,     // consume byte this cycle
    input  logic [BYTE_W-1:0]             byte_in,
    input  logic [LEN_W-1:0]              len,
    output scan_res_t                     res,
    output logic [MAX_PATTERN*BYTE_W-1:0] window_next
);

    logic              in_header_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [REC_W-1:0]  count_reg;
    logic [BYTE_W-1:0] win_reg  [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic              is_mark;
    logic              pos_sat;

    assign is_mark = (byte_in == HEADER_MARK);
    assign pos_sat = (pos_reg == POS_MAX);
    assign pos_next = pos_sat ? POS_MAX : pos_reg + POS_W'(1);

    always_comb
    begin
        win_next[0] = byte_in;
        for (int i = 1; i < MAX_PATTERN; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            window_next[i*BYTE_W +: BYTE_W] = win_next[i];
        end
    end

    // start = new position - len + 1, taken from the old position in parallel
    always_comb
    begin
        res.seq  = !is_mark && !in_header_reg;
        res.full = (pos_reg >= POS_W'(len) - POS_W'(1));
        res.end_pos = pos_next;
        if (pos_sat)
        begin
            res.start_pos = POS_MAX - POS_W'(len) + POS_W'(1);
        end
        else
        begin
            res.start_pos = pos_reg + POS_W'(2) - POS_W'(len);
        end
        res.rec = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_header_reg <= 1'b1;
            pos_reg       <= '0;
            count_reg     <= '0;
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            if (is_mark)
            begin
                in_header_reg <= 1'b1;
                pos_reg       <= '0;
                count_reg     <= count_reg + REC_W'(1);
            end
            else if (in_header_reg)
            begin
                if (byte_in == NEWLINE_CHAR)
                begin
                    in_header_reg <= 1'b0;
                end
            end
            else
            begin
                pos_reg <= pos_next;
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

endmodule

/* hdl/fasta_pattern_locator.sv */
// ----------------------------------------------------------------------------
// fasta_pattern_locator
// Exact pattern search over a Multi-FASTA byte stream, one byte per item.
//
// Channels: in_valid/in_ready carry stream_byte; out_valid/out_ready carry
// match_start, match_end, record_number; cfg_valid/cfg_ready write
// pattern_chars (index 0) or pattern_length (index 1) from cfg_data.
// cfg_ready is always high; write configuration only while the block is idle.
// A byte is held in the input register and is scanned as it leaves; a
// match is loaded into the output register at that same edge, which
// raises out_valid. Throughput: one byte per cycle while the output is
// not stalled, set by the single scan/compare step between input and
// output registers.
// Stall: while out_valid is high and out_ready low, the held byte waits and
// in_ready drops once the input register is full; nothing is lost.
// Reset: header mode, position and record count zero, window zero,
// pattern_chars zero, pattern_length one. Both registers empty.
// ----------------------------------------------------------------------------
`include "fasta_pattern_locator_assert.svh"

module fasta_pattern_locator
    import fpl_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // byte input
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    stream_byte,
    // match output
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_W-1:0]     match_start,
    output logic [POS_W-1:0]     match_end,
    output logic [REC_W-1:0]     record_number,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAT_W-1:0]     cfg_data
);

    // configuration registers
    logic [PAT_W-1:0] pat_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_act;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [POS_W-1:0]  start_reg;
    logic [POS_W-1:0]  end_reg;
    logic [REC_W-1:0]  rec_reg;

    logic              advance;
    logic              hit;
    logic              found;
    scan_res_t         scan;
    logic [MAX_PATTERN*BYTE_W-1:0] window_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            len_reg <= LEN_W'(1);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_PATTERN_CHARS)
            begin
                pat_reg <= cfg_data;
            end
            else if (cfg_index == REG_PATTERN_LENGTH)
            begin
                len_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    // zero acts as one, anything past the window depth as the depth
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            len_act = LEN_W'(1);
        end
        else if (len_reg > LEN_W'(MAX_PATTERN))
        begin
            len_act = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len_act = len_reg;
        end
    end

    // Held byte is scanned when the output slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= stream_byte;
        end
    end

    fpl_scan #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .byte_in     (in_byte_reg),
        .len         (len_act),
        .res         (scan),
        .window_next (window_next)
    );

    fpl_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .window  (window_next),
        .pattern (pat_reg),
        .len     (len_act),
        .hit     (hit)
    );

    assign found = advance && scan.seq && scan.full && hit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (found)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (found)
        begin
            start_reg <= scan.start_pos;
            end_reg   <= scan.end_pos;
            rec_reg   <= scan.rec;
        end
    end

    assign out_valid     = out_valid_reg;
    assign match_start   = start_reg;
    assign match_end     = end_reg;
    assign record_number = rec_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `FPL_ASSERT_NEXT(a_found_loads_out, clk, rst_n, found, out_valid_reg,
        "match found but output register not loaded")

    `FPL_ASSERT_SAME(a_no_overwrite, clk, rst_n, found,
        !out_valid_reg || out_ready, "pending match overwritten")

    `FPL_ASSERT_NEXT(a_held_byte_kept, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg, "stalled input byte dropped")

    `FPL_ASSERT_SAME(a_span_order, clk, rst_n, out_valid_reg,
        match_start <= match_end, "match start beyond match end")

endmodule
